// File: sv/counter_priority_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the counter/priority scheduler
// Define ASSERT_OFF to compile all checks away.
// ----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_SCHEDULER_TOP_DEFINES_SVH
`define COUNTER_PRIORITY_SCHEDULER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that is suspended while rst is high.
`define CSCHED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also holds during reset.
`define CSCHED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSCHED_ASSERT(lbl, prop, msg)
`define CSCHED_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/csched_pkg.sv
// ----------------------------------------------------------------------------
// csched_pkg
// Types and constants shared by the counter/priority scheduler modules.
// ----------------------------------------------------------------------------
package csched_pkg;

  // The slot field width fixes the size of the task table.
  localparam int SLOT_W = 4;
  localparam int TASKS  = 2 ** SLOT_W;
  localparam int CNT_W  = 8;
  localparam int PRIO_W = 7;
  localparam int TIME_W = 32;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_SLEEP  = 3'd1;
  localparam logic [2:0] CMD_EXIT   = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_PICK   = 3'd4;

  localparam logic [1:0] STAT_RUN   = 2'd0;
  localparam logic [1:0] STAT_SLEEP = 2'd1;
  localparam logic [1:0] STAT_EXIT  = 2'd2;

  typedef struct packed {
    logic [2:0]        command;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] wake_at;
  } csched_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] next_slot;
    logic              switched;
    logic              none_runnable;
  } csched_result_t;

  // One task table entry as held in the memory.
  typedef struct packed {
    logic [1:0]        status;
    logic [CNT_W-1:0]  counter;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] wakeup;
  } csched_entry_t;

  localparam int ENTRY_W = $bits(csched_entry_t);

endpackage

// File: sv/csched_ram.sv
// ----------------------------------------------------------------------------
// csched_ram
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module csched_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/counter_priority_scheduler_top.sv
// ----------------------------------------------------------------------------
// counter_priority_scheduler_top
// Counter/priority task scheduler with the task table held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfer is taken on a rising edge with start high and busy
//   low; item carries command, slot, prio, now_ms and wake_at. Every command
//   gives exactly one result on result, marked by done for a single cycle.
//   The receiver cannot hold results off.
//   Create, exit, unused codes and a tick without a pick need no scan; a
//   pick adds a scan of all TASKS entries and, when the best counter is
//   zero, a recompute scan of the same length. The scan length is set by
//   the single read port of the task RAM: each scan reads one entry a
//   cycle and writes it back in the cycle after.
//   One command is in flight at a time; busy is high until done is shown,
//   and a new command may be started in the cycle that done is high.
//   Reset clears the valid bits and the current slot; the RAM is not cleared
//   because an entry is used only after a create has written it.
// ----------------------------------------------------------------------------
`include "counter_priority_scheduler_top_defines.svh"

module counter_priority_scheduler_top
  import csched_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  csched_item_t   item,
  output logic           done,
  output csched_result_t result
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ACCESS = 5'b00010,
    S_MODIFY = 5'b00100,
    S_SCAN   = 5'b01000,
    S_RECALC = 5'b10000
  } state_t;

  state_t              state;
  csched_item_t        req;
  logic [SLOT_W-1:0]   cur_slot;
  logic [TASKS-1:0]    valid;
  logic [SLOT_W:0]     scan_idx;
  logic                p_vld;
  logic [SLOT_W-1:0]   p_idx;
  logic                best_found;
  logic [SLOT_W-1:0]   best_idx;
  logic [CNT_W-1:0]    best_cnt;

  logic                ram_wr_en;
  logic [SLOT_W-1:0]   ram_wr_addr;
  csched_entry_t       ram_wr_entry;
  logic                ram_rd_en;
  logic [SLOT_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0]  ram_rd_data;
  csched_entry_t       rd_entry;

  logic [PRIO_W-1:0]   prio_eff;
  logic [CNT_W-1:0]    cnt_dec;
  logic [CNT_W-1:0]    cnt_recalc;
  logic [1:0]          wake_status;
  logic [CNT_W-1:0]    cand_cnt;
  logic                cand_run;
  logic                better;
  logic                pass_end;
  logic                cur_valid;

  logic                fin;
  csched_result_t      fin_res;
  logic                go_modify;
  logic                go_scan;
  logic                go_recalc;

  csched_ram #(
    .DEPTH (TASKS),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_entry),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_entry  = csched_entry_t'(ram_rd_data);
  assign busy      = (state != S_IDLE);
  assign cur_valid = valid[cur_slot];
  assign prio_eff  = (req.prio == '0) ? PRIO_W'(1) : req.prio;
  assign cnt_dec   = (rd_entry.counter != '0) ? rd_entry.counter - CNT_W'(1) : '0;
  assign cnt_recalc = {1'b0, rd_entry.prio} + {1'b0, rd_entry.counter[CNT_W-1:1]};
  assign wake_status = (rd_entry.status != STAT_EXIT && req.now_ms > rd_entry.wakeup) ?
                       STAT_RUN : rd_entry.status;
  assign pass_end  = (scan_idx == (SLOT_W + 1)'(TASKS)) && !p_vld;

  // Candidate from the entry that the scan pipeline returns this cycle.
  always_comb begin
    cand_run = 1'b0;
    cand_cnt = rd_entry.counter;
    if (state == S_SCAN) begin
      cand_run = p_vld && valid[p_idx] && (wake_status == STAT_RUN);
    end else if (state == S_RECALC) begin
      cand_run = p_vld && valid[p_idx] && (rd_entry.status == STAT_RUN);
      cand_cnt = cnt_recalc;
    end
    better = cand_run && (!best_found || cand_cnt > best_cnt);
  end

  // RAM port control and the next step of the sequencer.
  always_comb begin
    ram_rd_en    = 1'b0;
    ram_rd_addr  = (req.command == CMD_EXIT) ? req.slot : cur_slot;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = ram_rd_addr;
    ram_wr_entry = rd_entry;
    fin          = 1'b0;
    fin_res      = '{next_slot: cur_slot, switched: 1'b0, none_runnable: 1'b0};
    go_modify    = 1'b0;
    go_scan      = 1'b0;
    go_recalc    = 1'b0;
    unique case (state)
      S_IDLE: begin
      end
      S_ACCESS: begin
        if (req.command == CMD_CREATE) begin
          ram_wr_en    = 1'b1;
          ram_wr_addr  = req.slot;
          ram_wr_entry = '{status: STAT_RUN, counter: {1'b0, prio_eff},
                           prio: prio_eff, wakeup: '0};
          fin          = 1'b1;
        end else if (req.command == CMD_PICK) begin
          go_scan = 1'b1;
        end else if (req.command == CMD_SLEEP || req.command == CMD_EXIT ||
                     req.command == CMD_TICK) begin
          ram_rd_en = 1'b1;
          go_modify = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      S_MODIFY: begin
        if (req.command == CMD_SLEEP) begin
          ram_wr_en           = cur_valid;
          ram_wr_entry.status = STAT_SLEEP;
          ram_wr_entry.wakeup = req.wake_at;
          go_scan             = 1'b1;
        end else if (req.command == CMD_EXIT) begin
          ram_wr_en           = valid[req.slot];
          ram_wr_entry.status = STAT_EXIT;
          fin                 = 1'b1;
        end else begin
          ram_wr_en            = cur_valid;
          ram_wr_entry.counter = cnt_dec;
          if (!cur_valid || cnt_dec == '0) begin
            go_scan = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_SCAN, S_RECALC: begin
        ram_rd_en   = (scan_idx != (SLOT_W + 1)'(TASKS));
        ram_rd_addr = scan_idx[SLOT_W-1:0];
        ram_wr_en   = p_vld && valid[p_idx];
        ram_wr_addr = p_idx;
        if (state == S_SCAN) begin
          ram_wr_entry.status = wake_status;
        end else begin
          ram_wr_entry.counter = cnt_recalc;
        end
        if (pass_end) begin
          if (!best_found) begin
            fin     = 1'b1;
            fin_res = '{next_slot: '0, switched: 1'b1, none_runnable: 1'b1};
          end else if (state == S_SCAN && best_cnt == '0) begin
            go_recalc = 1'b1;
          end else begin
            fin     = 1'b1;
            fin_res = '{next_slot: best_idx, switched: 1'b1, none_runnable: 1'b0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      cur_slot <= '0;
      done     <= 1'b0;
      p_vld    <= 1'b0;
    end else begin
      done  <= fin;
      p_vld <= ram_rd_en && (state == S_SCAN || state == S_RECALC);
      p_idx <= ram_rd_addr;
      if (better) begin
        best_found <= 1'b1;
        best_idx   <= p_idx;
        best_cnt   <= cand_cnt;
      end
      if ((state == S_SCAN || state == S_RECALC) && ram_rd_en) begin
        scan_idx <= scan_idx + (SLOT_W + 1)'(1);
      end
      if (state == S_IDLE && start) begin
        req   <= item;
        state <= S_ACCESS;
      end
      if (state == S_ACCESS && req.command == CMD_CREATE) begin
        valid[req.slot] <= 1'b1;
      end
      if (go_modify) begin
        state <= S_MODIFY;
      end
      // A new pass starts from slot zero with no best candidate.
      if (go_scan || go_recalc) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
        state      <= go_scan ? S_SCAN : S_RECALC;
      end
      if (fin) begin
        result   <= fin_res;
        cur_slot <= fin_res.next_slot;
        state    <= S_IDLE;
      end
    end
  end

  `CSCHED_ASSERT_ALWAYS(a_done_idle, done |-> state == S_IDLE, "result shown while busy")
  `CSCHED_ASSERT(a_none_slot0,
                 done && result.none_runnable |-> result.switched && result.next_slot == '0,
                 "empty pick must give slot 0")
  `CSCHED_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted command did not start")
  `CSCHED_ASSERT(a_cur_tracks, done |-> result.next_slot == cur_slot,
                 "current slot disagrees with result")
  `CSCHED_ASSERT(a_recalc_found, state == S_RECALC && pass_end |-> best_found,
                 "recompute found no runnable task")

endmodule

// File: test/counter_priority_scheduler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_priority_scheduler_top_tb
// Drives create, sleep, exit, tick and pick commands into the scheduler and
// checks every result against its typed-in value or a cycle-free model of
// the task table; short directed rows run first, then weighted random traffic.
// ----------------------------------------------------------------------------
module counter_priority_scheduler_top_tb
  import csched_pkg::*;
();

  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_TAIL    = 60;
  localparam int DRAIN_CYCLES = 60;
  localparam int NUM_DIRECTED = 25;

  typedef struct packed {
    csched_item_t   it;
    logic           known;
    csched_result_t res;
  } stim_row_t;

  // Rows with known set carry a result that is obvious from the command
  // history; the others are checked against the model.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{CMD_PICK,   4'd0,  7'd0,   32'd0,         32'd0},         1'b1, '{4'd0,  1'b1, 1'b1}},
    '{'{CMD_TICK,   4'd0,  7'd0,   32'hFFFF_FFFF, 32'd0},         1'b1, '{4'd0,  1'b1, 1'b1}},
    '{'{CMD_SLEEP,  4'd0,  7'd0,   32'd0,         32'hFFFF_FFFF}, 1'b1, '{4'd0,  1'b1, 1'b1}},
    '{'{CMD_EXIT,   4'd5,  7'd0,   32'd0,         32'd0},         1'b1, '{4'd0,  1'b0, 1'b0}},
    '{'{CMD_SPARE5, 4'd15, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{4'd0,  1'b0, 1'b0}},
    '{'{CMD_SPARE7, 4'd15, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{4'd0,  1'b0, 1'b0}},
    '{'{CMD_SPARE6, 4'd0,  7'd1,   32'd0,         32'd0},         1'b1, '{4'd0,  1'b0, 1'b0}},
    '{'{CMD_CREATE, 4'd15, 7'd127, 32'd0,         32'd0},         1'b1, '{4'd0,  1'b0, 1'b0}},
    '{'{CMD_CREATE, 4'd0,  7'd0,   32'd0,         32'd0},         1'b1, '{4'd0,  1'b0, 1'b0}},
    '{'{CMD_PICK,   4'd0,  7'd0,   32'd0,         32'd0},         1'b1, '{4'd15, 1'b1, 1'b0}},
    '{'{CMD_TICK,   4'd0,  7'd0,   32'd0,         32'd0},         1'b1, '{4'd15, 1'b0, 1'b0}},
    '{'{CMD_CREATE, 4'd3,  7'd127, 32'd0,         32'd0},         1'b1, '{4'd15, 1'b0, 1'b0}},
    '{'{CMD_PICK,   4'd0,  7'd0,   32'd0,         32'd0},         1'b1, '{4'd3,  1'b1, 1'b0}},
    '{'{CMD_SLEEP,  4'd0,  7'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{4'd15, 1'b1, 1'b0}},
    '{'{CMD_EXIT,   4'd15, 7'd0,   32'd0,         32'd0},         1'b1, '{4'd15, 1'b0, 1'b0}},
    '{'{CMD_PICK,   4'd0,  7'd0,   32'd0,         32'd0},         1'b0, '0},
    '{'{CMD_TICK,   4'd0,  7'd0,   32'd0,         32'd0},         1'b0, '0},
    '{'{CMD_SLEEP,  4'd0,  7'd0,   32'd0,         32'd0},         1'b0, '0},
    '{'{CMD_PICK,   4'd0,  7'd0,   32'd1,         32'd0},         1'b0, '0},
    '{'{CMD_EXIT,   4'd0,  7'd0,   32'd0,         32'd0},         1'b0, '0},
    '{'{CMD_PICK,   4'd0,  7'd0,   32'hFFFF_FFFF, 32'd0},         1'b0, '0},
    '{'{CMD_CREATE, 4'd3,  7'd1,   32'd0,         32'd0},         1'b0, '0},
    '{'{CMD_CREATE, 4'd9,  7'h55,  32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0},
    '{'{CMD_CREATE, 4'd10, 7'h2A,  32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0},
    '{'{CMD_PICK,   4'd0,  7'd0,   32'd0,         32'd0},         1'b0, '0}
  };

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  csched_item_t   item;
  logic           done;
  csched_result_t result;

  // Directed rows hand their typed-in result to the monitor along with the item.
  logic           row_known;
  csched_result_t row_result;

  csched_result_t due_decisions[$];
  csched_result_t predicted;
  csched_result_t want;
  int             mismatch_count = 0;

  // Model copy of the task table.
  bit                task_valid   [TASKS];
  logic [1:0]        task_status  [TASKS];
  logic [CNT_W-1:0]  task_counter [TASKS];
  logic [PRIO_W-1:0] task_prio    [TASKS];
  logic [TIME_W-1:0] task_wakeup  [TASKS];
  logic [SLOT_W-1:0] running_slot = '0;

  counter_priority_scheduler_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int best_ready();
    int best;
    best = -1;
    for (int i = 0; i < TASKS; i++) begin
      if (task_valid[i] && task_status[i] == STAT_RUN &&
          (best < 0 || task_counter[i] > task_counter[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic csched_result_t pick_task(input logic [TIME_W-1:0] now);
    csched_result_t r;
    int             best;
    for (int i = 0; i < TASKS; i++) begin
      if (task_valid[i] && task_status[i] != STAT_EXIT && now > task_wakeup[i]) begin
        task_status[i] = STAT_RUN;
      end
    end
    best = best_ready();
    r.switched      = 1'b1;
    r.none_runnable = 1'b0;
    if (best < 0) begin
      running_slot    = '0;
      r.next_slot     = '0;
      r.none_runnable = 1'b1;
      return r;
    end
    // All runnable slices used up: refill every valid task, then choose again.
    if (task_counter[best] == '0) begin
      for (int i = 0; i < TASKS; i++) begin
        if (task_valid[i]) begin
          task_counter[i] = task_prio[i] + (task_counter[i] >> 1);
        end
      end
      best = best_ready();
    end
    running_slot = SLOT_W'(best);
    r.next_slot  = running_slot;
    return r;
  endfunction

  function automatic csched_result_t schedule_step(input csched_item_t it);
    csched_result_t    r;
    logic [PRIO_W-1:0] p;
    bit                want_pick;
    want_pick = 1'b0;
    case (it.command)
      CMD_CREATE: begin
        p = (it.prio == '0) ? PRIO_W'(1) : it.prio;
        task_valid[it.slot]   = 1'b1;
        task_status[it.slot]  = STAT_RUN;
        task_prio[it.slot]    = p;
        task_counter[it.slot] = CNT_W'(p);
        task_wakeup[it.slot]  = '0;
      end
      CMD_SLEEP: begin
        if (task_valid[running_slot]) begin
          task_wakeup[running_slot] = it.wake_at;
          task_status[running_slot] = STAT_SLEEP;
        end
        want_pick = 1'b1;
      end
      CMD_EXIT: begin
        if (task_valid[it.slot]) begin
          task_status[it.slot] = STAT_EXIT;
        end
      end
      CMD_TICK: begin
        if (task_valid[running_slot]) begin
          if (task_counter[running_slot] != '0) begin
            task_counter[running_slot] = task_counter[running_slot] - 1'b1;
          end
          want_pick = (task_counter[running_slot] == '0);
        end else begin
          want_pick = 1'b1;
        end
      end
      CMD_PICK: begin
        want_pick = 1'b1;
      end
      default: begin
      end
    endcase
    if (want_pick) begin
      return pick_task(it.now_ms);
    end
    r.next_slot     = running_slot;
    r.switched      = 1'b0;
    r.none_runnable = 1'b0;
    return r;
  endfunction

  // Inputs are sampled at the edge before any of this step's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (due_decisions.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result slot=%0d switched=%0b none=%0b", $realtime,
                     result.next_slot, result.switched, result.none_runnable);
          end
        end else begin
          want = due_decisions.pop_front();
          if (result.next_slot !== want.next_slot || result.switched !== want.switched ||
              result.none_runnable !== want.none_runnable) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected slot=%0d sw=%0b none=%0b, got slot=%0d sw=%0b none=%0b",
                       $realtime, want.next_slot, want.switched, want.none_runnable,
                       result.next_slot, result.switched, result.none_runnable);
            end
          end
        end
      end
      if (start && !busy) begin
        predicted = schedule_step(item);
        due_decisions.push_back(row_known ? row_result : predicted);
      end
    end
  end

  // Presents one command, maybe after an idle burst, and returns at the edge
  // that takes the transfer. start stays high for a following command.
  task automatic issue(input csched_item_t it, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    csched_item_t      it;
    logic [TIME_W-1:0] sim_ms;
    int                roll;
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    row_known  = 1'b0;
    row_result = '0;
    sim_ms     = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row_known  <= DIRECTED_ROWS[r].known;
      row_result <= DIRECTED_ROWS[r].res;
      issue(DIRECTED_ROWS[r].it, 1'b1);
    end
    row_known <= 1'b0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Once midway, hold off until the scheduler has answered everything.
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (!done);
      end
      if ($urandom_range(0, 9) == 0) begin
        sim_ms = $urandom;
      end else begin
        sim_ms = sim_ms + $urandom_range(0, 20);
      end
      it.now_ms  = sim_ms;
      it.wake_at = ($urandom_range(0, 7) == 0) ? TIME_W'($urandom)
                                               : sim_ms + $urandom_range(0, 60);
      it.slot    = SLOT_W'($urandom_range(0, TASKS - 1));
      // Small priorities keep slices short so refills happen often.
      it.prio    = ($urandom_range(0, 4) == 0) ? PRIO_W'($urandom_range(0, 127))
                                               : PRIO_W'($urandom_range(1, 6));
      roll = $urandom_range(0, 99);
      if (roll < 18) begin
        it.command = CMD_CREATE;
      end else if (roll < 26) begin
        it.command = CMD_SLEEP;
      end else if (roll < 32) begin
        it.command = CMD_EXIT;
      end else if (roll < 70) begin
        it.command = CMD_TICK;
      end else if (roll < 97) begin
        it.command = CMD_PICK;
      end else begin
        it.command = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
      end
      issue(it, n < RANDOM_ITEMS - CALM_TAIL);
    end
    start <= 1'b0;

    while (due_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_decisions.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
